/* design/tournament_branch_predictor_top_defines.svh */
// ----------------------------------------------------------------------------
// Tournament branch predictor assertion macros
// Shared helpers for concurrent checks clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_BRANCH_PREDICTOR_TOP_DEFINES_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define TBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TBP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tbp_pkg.sv */
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Table sizes, shared types and small helper functions.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int unsigned MAX_GLOBAL_BITS   = 12;
  localparam int unsigned MAX_LOCAL_BITS    = 12;
  localparam int unsigned MAX_PC_INDEX_BITS = 12;

  localparam int unsigned PC_W      = 32;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned CTR_W     = 2;

  // clear sweep covers the deepest table
  localparam int unsigned CLR_W =
    (MAX_GLOBAL_BITS > MAX_LOCAL_BITS) ?
      ((MAX_GLOBAL_BITS > MAX_PC_INDEX_BITS) ? MAX_GLOBAL_BITS : MAX_PC_INDEX_BITS) :
      ((MAX_LOCAL_BITS > MAX_PC_INDEX_BITS) ? MAX_LOCAL_BITS : MAX_PC_INDEX_BITS);

  localparam logic [CFG_W-1:0] GLOBAL_BITS_RST   = CFG_W'(9);
  localparam logic [CFG_W-1:0] LOCAL_BITS_RST    = CFG_W'(10);
  localparam logic [CFG_W-1:0] PC_INDEX_BITS_RST = CFG_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLOBAL_BITS   = 2'd0,
    CFG_LOCAL_BITS    = 2'd1,
    CFG_PC_INDEX_BITS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [MAX_GLOBAL_BITS-1:0]   gmask;
    logic [MAX_LOCAL_BITS-1:0]    lmask;
    logic [MAX_PC_INDEX_BITS-1:0] pmask;
  } mask_t;

  typedef struct packed {
    logic             adv;
    logic             clr;
    logic [CLR_W-1:0] clr_addr;
  } ctl_t;

  typedef struct packed {
    logic                       valid;
    logic                       taken;
    logic [MAX_LOCAL_BITS-1:0]  lidx;
    logic [MAX_GLOBAL_BITS-1:0] gidx;
  } s1_t;

  // length 0 acts as 1, lengths above the table size clamp to it
  function automatic logic [MASK_W-1:0] width_mask(input logic [CFG_W-1:0] v,
                                                   input int unsigned max_bits);
    logic [4:0] b;
    b = {1'b0, v};
    if (b == 5'd0) b = 5'd1;
    if (32'(b) > max_bits) b = 5'(max_bits);
    return ~({MASK_W{1'b1}} << b);
  endfunction

  function automatic logic [CTR_W-1:0] sat_move(input logic [CTR_W-1:0] c,
                                                input logic up);
    logic [CTR_W-1:0] r;
    r = c;
    if (up) begin
      if (c != {CTR_W{1'b1}}) r = c + CTR_W'(1);
    end else begin
      if (c != {CTR_W{1'b0}}) r = c - CTR_W'(1);
    end
    return r;
  endfunction

endpackage

/* design/tbp_cfg.sv */
// ----------------------------------------------------------------------------
// Tournament branch predictor configuration registers
// Holds the history and index lengths as ready-made bit masks.
// ----------------------------------------------------------------------------
module tbp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tbp_pkg::CFG_W-1:0]      cfg_data_i,
  output tbp_pkg::mask_t                 mask_o
);

  localparam int unsigned GW = tbp_pkg::MAX_GLOBAL_BITS;
  localparam int unsigned LW = tbp_pkg::MAX_LOCAL_BITS;
  localparam int unsigned PW = tbp_pkg::MAX_PC_INDEX_BITS;

  localparam logic [tbp_pkg::MASK_W-1:0] GMaskRst =
    tbp_pkg::width_mask(tbp_pkg::GLOBAL_BITS_RST, tbp_pkg::MAX_GLOBAL_BITS);
  localparam logic [tbp_pkg::MASK_W-1:0] LMaskRst =
    tbp_pkg::width_mask(tbp_pkg::LOCAL_BITS_RST, tbp_pkg::MAX_LOCAL_BITS);
  localparam logic [tbp_pkg::MASK_W-1:0] PMaskRst =
    tbp_pkg::width_mask(tbp_pkg::PC_INDEX_BITS_RST, tbp_pkg::MAX_PC_INDEX_BITS);

  logic [tbp_pkg::MASK_W-1:0] gmask_new;
  logic [tbp_pkg::MASK_W-1:0] lmask_new;
  logic [tbp_pkg::MASK_W-1:0] pmask_new;
  tbp_pkg::mask_t             mask_q;

  assign gmask_new = tbp_pkg::width_mask(cfg_data_i, tbp_pkg::MAX_GLOBAL_BITS);
  assign lmask_new = tbp_pkg::width_mask(cfg_data_i, tbp_pkg::MAX_LOCAL_BITS);
  assign pmask_new = tbp_pkg::width_mask(cfg_data_i, tbp_pkg::MAX_PC_INDEX_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q.gmask <= GMaskRst[GW-1:0];
      mask_q.lmask <= LMaskRst[LW-1:0];
      mask_q.pmask <= PMaskRst[PW-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbp_pkg::CFG_GLOBAL_BITS:   mask_q.gmask <= gmask_new[GW-1:0];
        tbp_pkg::CFG_LOCAL_BITS:    mask_q.lmask <= lmask_new[LW-1:0];
        tbp_pkg::CFG_PC_INDEX_BITS: mask_q.pmask <= pmask_new[PW-1:0];
        default: ;
      endcase
    end
  end

  assign mask_o = mask_q;

endmodule

/* design/tbp_hist.sv */
// ----------------------------------------------------------------------------
// Tournament branch predictor history stage
// Global history register and per-pc local history table; forms both
// counter indexes for the next stage.
// ----------------------------------------------------------------------------
module tbp_hist (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tbp_pkg::ctl_t             ctl_i,
  input  tbp_pkg::mask_t            mask_i,
  input  logic                      accept_i,
  input  logic [tbp_pkg::PC_W-1:0]  branch_pc_i,
  input  logic                      actual_taken_i,
  output tbp_pkg::s1_t              s1_o
);

  localparam int unsigned GW   = tbp_pkg::MAX_GLOBAL_BITS;
  localparam int unsigned LW   = tbp_pkg::MAX_LOCAL_BITS;
  localparam int unsigned PW   = tbp_pkg::MAX_PC_INDEX_BITS;
  localparam int unsigned PTab = 1 << PW;

  logic [LW-1:0] lht_mem [PTab];

  logic          valid_q;
  logic [GW-1:0] ghist_q;
  logic [GW-1:0] ghist_d;
  logic [PW-1:0] pidx_q;
  logic          taken_q;
  logic [GW-1:0] gidx_q;
  logic [LW-1:0] rd_q;
  logic          byp_q;
  logic [LW-1:0] byp_data_q;

  logic [PW-1:0] pidx_in;
  logic          item_wr;
  logic [LW-1:0] hist_cur;
  logic [LW-1:0] hist_new;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [LW-1:0] wr_data;

  assign pidx_in  = branch_pc_i[PW-1:0] & mask_i.pmask;
  assign ghist_d  = GW'({ghist_q, actual_taken_i}) & mask_i.gmask;
  assign item_wr  = ctl_i.adv && valid_q;
  // previous request may have written this entry on the edge we read it
  assign hist_cur = byp_q ? byp_data_q : rd_q;
  assign hist_new = LW'({hist_cur, taken_q}) & mask_i.lmask;

  assign wr_en   = ctl_i.clr || item_wr;
  assign wr_addr = ctl_i.clr ? ctl_i.clr_addr[PW-1:0] : pidx_q;
  assign wr_data = ctl_i.clr ? '0 : hist_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ghist_q <= '0;
    end else if (ctl_i.adv) begin
      valid_q <= accept_i;
      if (accept_i) ghist_q <= ghist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pidx_q     <= pidx_in;
      taken_q    <= actual_taken_i;
      gidx_q     <= ghist_q & mask_i.gmask;
      byp_q      <= item_wr && (pidx_q == pidx_in);
      byp_data_q <= hist_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) lht_mem[wr_addr] <= wr_data;
    if (accept_i) rd_q <= lht_mem[pidx_in];
  end

  assign s1_o.valid = valid_q;
  assign s1_o.taken = taken_q;
  assign s1_o.lidx  = hist_cur & mask_i.lmask;
  assign s1_o.gidx  = gidx_q;

endmodule

/* design/tbp_ctr.sv */
// ----------------------------------------------------------------------------
// Tournament branch predictor counter stage
// Local, global and chooser counter tables; picks the prediction, trains
// the counters and holds the result register.
// ----------------------------------------------------------------------------
module tbp_ctr (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tbp_pkg::ctl_t ctl_i,
  input  tbp_pkg::s1_t  s1_i,
  output logic          out_valid_o,
  output logic          predicted_taken_o,
  output logic          chose_global_o
);

  localparam int unsigned GW   = tbp_pkg::MAX_GLOBAL_BITS;
  localparam int unsigned LW   = tbp_pkg::MAX_LOCAL_BITS;
  localparam int unsigned CW   = tbp_pkg::CTR_W;
  localparam int unsigned LTab = 1 << LW;
  localparam int unsigned GTab = 1 << GW;

  logic [CW-1:0] lctr_mem [LTab];
  logic [CW-1:0] gctr_mem [GTab];
  logic [CW-1:0] cctr_mem [GTab];

  logic          valid_q;
  logic          out_valid_q;
  logic          taken_q;
  logic [LW-1:0] lidx_q;
  logic [GW-1:0] gidx_q;
  logic          lbyp_q;
  logic          gbyp_q;
  logic [CW-1:0] lbyp_data_q;
  logic [CW-1:0] gbyp_data_q;
  logic [CW-1:0] cbyp_data_q;
  logic [CW-1:0] lrd_q;
  logic [CW-1:0] grd_q;
  logic [CW-1:0] crd_q;
  logic          pred_q;
  logic          chose_q;

  logic          rd_en;
  logic          item_wr;
  logic [CW-1:0] lc;
  logic [CW-1:0] gc;
  logic [CW-1:0] cc;
  logic          lpred;
  logic          gpred;
  logic          use_g;
  logic          pred;
  logic [CW-1:0] lnew;
  logic [CW-1:0] gnew;
  logic [CW-1:0] cnew;
  logic          wr_en;
  logic [LW-1:0] lwr_addr;
  logic [GW-1:0] gwr_addr;

  assign rd_en   = ctl_i.adv && s1_i.valid;
  assign item_wr = ctl_i.adv && valid_q;

  // the request ahead writes back on the same edge this one reads
  assign lc = lbyp_q ? lbyp_data_q : lrd_q;
  assign gc = gbyp_q ? gbyp_data_q : grd_q;
  assign cc = gbyp_q ? cbyp_data_q : crd_q;

  assign lpred = lc[CW-1];
  assign gpred = gc[CW-1];
  assign use_g = cc[CW-1];
  assign pred  = use_g ? gpred : lpred;

  assign lnew = tbp_pkg::sat_move(lc, taken_q);
  assign gnew = tbp_pkg::sat_move(gc, taken_q);
  // chooser only learns when the two sides disagree
  assign cnew = (lpred != gpred) ? tbp_pkg::sat_move(cc, gpred == taken_q) : cc;

  assign wr_en    = ctl_i.clr || item_wr;
  assign lwr_addr = ctl_i.clr ? ctl_i.clr_addr[LW-1:0] : lidx_q;
  assign gwr_addr = ctl_i.clr ? ctl_i.clr_addr[GW-1:0] : gidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (ctl_i.adv) begin
      valid_q     <= s1_i.valid;
      out_valid_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      taken_q     <= s1_i.taken;
      lidx_q      <= s1_i.lidx;
      gidx_q      <= s1_i.gidx;
      lbyp_q      <= item_wr && (lidx_q == s1_i.lidx);
      gbyp_q      <= item_wr && (gidx_q == s1_i.gidx);
      lbyp_data_q <= lnew;
      gbyp_data_q <= gnew;
      cbyp_data_q <= cnew;
    end
    if (item_wr) begin
      pred_q  <= pred;
      chose_q <= use_g;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lctr_mem[lwr_addr] <= ctl_i.clr ? '0 : lnew;
      gctr_mem[gwr_addr] <= ctl_i.clr ? '0 : gnew;
      cctr_mem[gwr_addr] <= ctl_i.clr ? '0 : cnew;
    end
    if (rd_en) begin
      lrd_q <= lctr_mem[s1_i.lidx];
      grd_q <= gctr_mem[s1_i.gidx];
      crd_q <= cctr_mem[s1_i.gidx];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign predicted_taken_o = pred_q;
  assign chose_global_o    = chose_q;

endmodule

/* design/tournament_branch_predictor_top.sv */
// ----------------------------------------------------------------------------
// Tournament branch predictor top level
// Requests pass the registered read of the history table, then of the counter
// tables, into the result register; one request per cycle while it is not held.
// After reset a sweep zeroes all tables; input stalls meanwhile.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tbp_pkg::PC_W-1:0]       branch_pc_i,
  input  logic                           actual_taken_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           predicted_taken_o,
  output logic                           chose_global_o,
  input  logic                           cfg_we_i,
  input  logic [tbp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tbp_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned CW = tbp_pkg::CLR_W;

  logic           clr_q;
  logic [CW-1:0]  clr_addr_q;
  logic           out_valid;
  logic           accept;
  tbp_pkg::ctl_t  ctl;
  tbp_pkg::mask_t mask;
  tbp_pkg::s1_t   s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + CW'(1);
      if (clr_addr_q == {CW{1'b1}}) clr_q <= 1'b0;
    end
  end

  // whole pipeline moves together; only a full, stalled result register holds it
  assign ctl.adv      = !(out_valid && out_stall_i);
  assign ctl.clr      = clr_q;
  assign ctl.clr_addr = clr_addr_q;

  assign in_stall_o = clr_q || !ctl.adv;
  assign accept     = in_valid_i && !in_stall_o;

  tbp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .mask_o     (mask)
  );

  tbp_hist u_hist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .mask_i         (mask),
    .accept_i       (accept),
    .branch_pc_i    (branch_pc_i),
    .actual_taken_i (actual_taken_i),
    .s1_o           (s1)
  );

  tbp_ctr u_ctr (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .s1_i              (s1),
    .out_valid_o       (out_valid),
    .predicted_taken_o (predicted_taken_o),
    .chose_global_o    (chose_global_o)
  );

  assign out_valid_o = out_valid;

endmodule

/* design/tbp_checker.sv */
// ----------------------------------------------------------------------------
// Tournament branch predictor port checker
// Watches the top-level handshakes for reset sweep, backpressure and drain.
// ----------------------------------------------------------------------------
`include "tournament_branch_predictor_top_defines.svh"

module tbp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_i,
  input logic out_valid_i,
  input logic out_stall_i,
  input logic predicted_taken_i,
  input logic chose_global_i
);

  logic idle;

  // no request taken and nothing holding the result register
  assign idle = !(in_valid_i && !in_stall_i) && !out_stall_i;

  `TBP_ASSERT_IMP(a_clear_after_reset, !$past(rst_ni), in_stall_i, "request taken during table clear")
  `TBP_ASSERT_IMP(a_backpressure, out_valid_i && out_stall_i, in_stall_i, "request taken while result held")
  `TBP_ASSERT_NXT(a_result_hold, out_valid_i && out_stall_i, out_valid_i && $stable(predicted_taken_i) && $stable(chose_global_i), "stalled result changed")
  `TBP_ASSERT_IMP(a_drain, $past(idle, 1) && $past(idle, 2) && $past(idle, 3), !out_valid_i, "result without a request")

endmodule

bind tournament_branch_predictor_top tbp_checker u_tbp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_i        (in_stall_o),
  .out_valid_i       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .predicted_taken_i (predicted_taken_o),
  .chose_global_i    (chose_global_o)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Tournament branch predictor testbench
// Drives resolved branches through the valid/stall request channel, predicts
// each result with a local copy of the history and counter tables, and checks
// prediction and chooser side against the block, under random idling on both
// sides and over several history length settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned PIPE_LATENCY = 3;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned POOL_W       = 3;
  localparam int unsigned POOL_SIZE    = 1 << POOL_W;

  localparam int unsigned GW = tbp_pkg::MAX_GLOBAL_BITS;
  localparam int unsigned LW = tbp_pkg::MAX_LOCAL_BITS;
  localparam int unsigned PW = tbp_pkg::MAX_PC_INDEX_BITS;

  // index past the register list, writes to it are dropped
  localparam logic [tbp_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct {
    logic pred_taken;
    logic use_glob;
  } prediction_t;

  typedef enum int {
    PAT_ALWAYS,
    PAT_NEVER,
    PAT_LOOP,
    PAT_ALTERNATE,
    PAT_RANDOM
  } branch_pattern_e;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic [tbp_pkg::PC_W-1:0]      branch_pc_i    = '0;
  logic                          actual_taken_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic                          predicted_taken_o;
  logic                          chose_global_o;
  logic                          cfg_we_i       = 1'b0;
  logic [tbp_pkg::CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [tbp_pkg::CFG_W-1:0]     cfg_data_i     = '0;

  tournament_branch_predictor_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .branch_pc_i       (branch_pc_i),
    .actual_taken_i    (actual_taken_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .predicted_taken_o (predicted_taken_o),
    .chose_global_o    (chose_global_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // predictor copy of the block state
  logic [tbp_pkg::CFG_W-1:0] glob_len;
  logic [tbp_pkg::CFG_W-1:0] local_len;
  logic [tbp_pkg::CFG_W-1:0] pc_len;
  logic [GW-1:0]             glob_hist;
  logic [LW-1:0]             local_hist  [(1 << PW)];
  logic [tbp_pkg::CTR_W-1:0] local_ctr   [(1 << LW)];
  logic [tbp_pkg::CTR_W-1:0] glob_ctr    [(1 << GW)];
  logic [tbp_pkg::CTR_W-1:0] chooser_ctr [(1 << GW)];

  prediction_t expected_predictions[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          no_idle    = 1'b0;

  logic [tbp_pkg::PC_W-1:0] pool_pc     [POOL_SIZE];
  branch_pattern_e          pool_kind   [POOL_SIZE];
  int unsigned              pool_period [POOL_SIZE];
  int unsigned              pool_count  [POOL_SIZE];

  function automatic int unsigned len_mask(input logic [tbp_pkg::CFG_W-1:0] v,
                                           input int unsigned max_bits);
    int unsigned b;
    b = 32'(v);
    if (b < 1) b = 1;
    if (b > max_bits) b = max_bits;
    return (32'd1 << b) - 32'd1;
  endfunction

  function automatic logic [tbp_pkg::CTR_W-1:0] ctr_step(
      input logic [tbp_pkg::CTR_W-1:0] c, input logic up);
    if (up) return (c == 2'd3) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  function automatic void clear_tables();
    glob_len  = tbp_pkg::GLOBAL_BITS_RST;
    local_len = tbp_pkg::LOCAL_BITS_RST;
    pc_len    = tbp_pkg::PC_INDEX_BITS_RST;
    glob_hist = '0;
    foreach (local_hist[i]) local_hist[i] = '0;
    foreach (local_ctr[i]) local_ctr[i] = '0;
    foreach (glob_ctr[i]) glob_ctr[i] = '0;
    foreach (chooser_ctr[i]) chooser_ctr[i] = '0;
  endfunction

  // forms the prediction from the current tables, then trains them
  function automatic prediction_t predict_branch(input logic [tbp_pkg::PC_W-1:0] pc,
                                                 input logic taken);
    int unsigned gmask, lmask, pmask;
    logic [PW-1:0] pidx;
    logic [LW-1:0] lidx;
    logic [GW-1:0] gidx;
    logic          lp, gp, ug;
    prediction_t   res;
    gmask = len_mask(glob_len, GW);
    lmask = len_mask(local_len, LW);
    pmask = len_mask(pc_len, PW);
    pidx  = PW'(pc & pmask);
    lidx  = LW'(32'(local_hist[pidx]) & lmask);
    gidx  = GW'(32'(glob_hist) & gmask);
    lp    = local_ctr[lidx][1];
    gp    = glob_ctr[gidx][1];
    ug    = chooser_ctr[gidx][1];
    res.pred_taken = ug ? gp : lp;
    res.use_glob   = ug;
    local_ctr[lidx] = ctr_step(local_ctr[lidx], taken);
    local_hist[pidx] = LW'(((32'(local_hist[pidx]) << 1) | 32'(taken)) & lmask);
    glob_ctr[gidx] = ctr_step(glob_ctr[gidx], taken);
    glob_hist = GW'(((32'(glob_hist) << 1) | 32'(taken)) & gmask);
    if (lp != gp) chooser_ctr[gidx] = ctr_step(chooser_ctr[gidx], gp == taken);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // entered and left at a rising edge; valid stays high after acceptance
  task automatic send_branch(input logic [tbp_pkg::PC_W-1:0] pc, input logic taken);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    branch_pc_i    <= pc;
    actual_taken_i <= taken;
    do @(posedge clk_i); while (in_stall_o);
    expected_predictions.push_back(predict_branch(pc, taken));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_predictions.size() > 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [tbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tbp_pkg::CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tbp_pkg::CFG_GLOBAL_BITS:   glob_len  = val;
      tbp_pkg::CFG_LOCAL_BITS:    local_len = val;
      tbp_pkg::CFG_PC_INDEX_BITS: pc_len    = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_lengths(input logic [tbp_pkg::CFG_W-1:0] g,
                               input logic [tbp_pkg::CFG_W-1:0] l,
                               input logic [tbp_pkg::CFG_W-1:0] p);
    wait_drain();
    write_cfg(tbp_pkg::CFG_GLOBAL_BITS, g);
    write_cfg(tbp_pkg::CFG_LOCAL_BITS, l);
    write_cfg(tbp_pkg::CFG_PC_INDEX_BITS, p);
  endtask

  function automatic logic [tbp_pkg::CFG_W-1:0] pick_length();
    case ($urandom_range(0, 4))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd12;
      3: return 4'd15;
      default: return tbp_pkg::CFG_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic void build_pool();
    foreach (pool_pc[i]) begin
      pool_pc[i]     = $urandom();
      pool_kind[i]   = branch_pattern_e'($urandom_range(0, 4));
      pool_period[i] = $urandom_range(2, 7);
      pool_count[i]  = 0;
    end
  endfunction

  function automatic logic next_direction(input logic [POOL_W-1:0] i);
    logic d;
    case (pool_kind[i])
      PAT_ALWAYS:    d = 1'b1;
      PAT_NEVER:     d = 1'b0;
      PAT_LOOP:      d = (pool_count[i] % pool_period[i]) != pool_period[i] - 1;
      PAT_ALTERNATE: d = pool_count[i][0];
      default:       d = 1'($urandom_range(0, 1));
    endcase
    pool_count[i]++;
    return d;
  endfunction

  // result side: random stall before each result, then check on acceptance
  always begin
    int unsigned hold;
    prediction_t exp_res;
    hold = no_idle ? 0 : $urandom_range(0, 5);
    if (hold > 0) begin
      out_stall_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
    end
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    if (expected_predictions.size() == 0) begin
      report_mismatch("result with no request pending");
    end else begin
      exp_res = expected_predictions.pop_front();
      if (predicted_taken_o !== exp_res.pred_taken)
        report_mismatch($sformatf("predicted_taken exp %0b got %0b",
                                  exp_res.pred_taken, predicted_taken_o));
      if (chose_global_o !== exp_res.use_glob)
        report_mismatch($sformatf("chose_global exp %0b got %0b",
                                  exp_res.use_glob, chose_global_o));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // reset lengths, extreme pcs, repeated pc so counters move
  task automatic test_reset_config();
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b1);
  endtask

  // zero lengths act as one bit, lengths past the table size clamp
  task automatic test_length_extremes();
    write_lengths(4'd0, 4'd0, 4'd0);
    send_branch(32'h0000_0001, 1'b1);
    send_branch(32'h0000_0002, 1'b1);
    send_branch(32'h0000_0003, 1'b0);
    send_branch(32'hFFFF_FFFE, 1'b1);
    send_branch(32'h0000_0001, 1'b0);
    write_lengths(4'd15, 4'd15, 4'd15);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_0FFF, 1'b1);
    send_branch(32'hFFFF_F000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_0FFF, 1'b0);
    // shrink without clearing: stored histories get masked
    write_lengths(4'd1, 4'd2, 4'd3);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_0FFF, 1'b1);
    send_branch(32'hFFFF_F000, 1'b0);
  endtask

  task automatic test_ignored_index();
    wait_drain();
    write_cfg(CFG_IDX_UNUSED, 4'd0);
    write_cfg(CFG_IDX_UNUSED, 4'd15);
    send_branch(32'h1234_5678, 1'b1);
    send_branch(32'h8765_4321, 1'b0);
    send_branch(32'h1234_5678, 1'b1);
  endtask

  task automatic test_random_traces();
    logic [POOL_W-1:0] slot;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) write_lengths(4'd12, 4'd12, 4'd12);
      else write_lengths(pick_length(), pick_length(), pick_length());
      if ($urandom_range(0, 1))
        write_cfg(CFG_IDX_UNUSED, tbp_pkg::CFG_W'($urandom_range(0, 15)));
      no_idle = (phase == 2);
      build_pool();
      slot = '0;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) < 8) begin
          send_branch(pool_pc[slot], next_direction(slot));
          slot = slot + POOL_W'(1);
          // occasional jump breaks the program order
          if ($urandom_range(0, 15) == 0) slot = POOL_W'($urandom_range(0, POOL_SIZE - 1));
        end else begin
          send_branch($urandom(), 1'($urandom_range(0, 1)));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // sender holds off until every pending result is back, then resumes
  task automatic test_drain_pause();
    for (int n = 0; n < 20; n++) send_branch($urandom(), 1'($urandom_range(0, 1)));
    wait_drain();
    for (int n = 0; n < 20; n++) send_branch($urandom(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    clear_tables();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_config();
    test_length_extremes();
    test_ignored_index();
    test_random_traces();
    test_drain_pause();
    wait_drain();
    repeat (PIPE_LATENCY + 5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
